// File: rtl/tspm_pkg.sv
`default_nettype none
package tspm_pkg;

  localparam int MAX_SIDE  = 1024;
  localparam int FRAC_BITS = 12;

  localparam int SIDE_W = 11;
  localparam int DIF_W  = 12;
  localparam int VEL_W  = 17;
  localparam int ACC_W  = 46;

  // ceil(2^23 / 10), exact floor quotient for dividends below 2^20
  localparam int RECIP_SH = 23;
  localparam logic signed [20:0] RECIP_10 = 21'sd838861;

  typedef enum logic [2:0] {
    REG_GRID_HEIGHT = 3'd0,
    REG_GRID_WIDTH  = 3'd1,
    REG_COG_WEIGHT  = 3'd2,
    REG_SOC_WEIGHT  = 3'd3,
    REG_SPEED_LIMIT = 3'd4,
    REG_START_INER  = 3'd5,
    REG_INER_DEC    = 3'd6,
    REG_PHASE_GENS  = 3'd7
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MOD  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] r);
    if (r < SIDE_W'(3)) return SIDE_W'(3);
    if (r > SIDE_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
    return r;
  endfunction

  // fold a difference to its shortest form around the ring
  function automatic logic signed [DIF_W-1:0] shortest(input logic signed [DIF_W-1:0] d,
                                                        input logic [SIDE_W-1:0] side);
    logic signed [DIF_W:0] dx;
    logic signed [DIF_W:0] s;
    logic [DIF_W:0] mag;
    logic [DIF_W:0] half;
    dx   = (DIF_W+1)'(d);
    s    = $signed({2'b00, side});
    mag  = dx[DIF_W] ? (DIF_W+1)'(-dx) : (DIF_W+1)'(dx);
    half = {3'b000, side[SIDE_W-1:1]};
    if (mag > half) dx = dx[DIF_W] ? dx + s : dx - s;
    return dx[DIF_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/toroidal_swarm_particle_move.sv
// Toroidal particle-swarm move, one particle per item.
// Input channel in_*: valid/ready; in_ready is high only while the block is idle.
// Result channel out_*: valid/ready from an output register; one result per item.
// Config port cfg_*: write enable, index, 16-bit data. The config registers
// must be written only while idle; the block itself does not enforce it.
// Each item runs through one shared 33x21 multiplier under a small sequencer:
//   an idle state in which the item is captured and wrapped,
//   the eight products of both components,
//   a speed check, and a 9/10 shrink pass each time the check fails,
//   the two position modulos (11 shift-subtract steps each),
//   the hand-off to the output register.
// Shrink passes repeat until the speed is within the limit; there is none when it
// already is. A new item is taken only after the previous one is handed off.
// The next item is taken while the previous result still sits in the output
// register; a result only blocks the hand-off when the receiver is still holding
// the one before it.
// Reset (synchronous, active low) restores the config and control registers to
// their defaults, inertia to its start value and the generation count to zero.
`default_nettype none
module toroidal_swarm_particle_move import tspm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  in_pos_row,
  input  wire logic [9:0]  in_pos_col,
  input  wire logic signed [10:0] in_vel_row,
  input  wire logic signed [10:0] in_vel_col,
  input  wire logic [9:0]  in_own_best_row,
  input  wire logic [9:0]  in_own_best_col,
  input  wire logic [9:0]  in_swarm_best_row,
  input  wire logic [9:0]  in_swarm_best_col,
  input  wire logic [15:0] in_rand_cognitive,
  input  wire logic [15:0] in_rand_social,
  input  wire logic        in_last_of_generation,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_new_row,
  output logic [9:0]       out_new_col,
  output logic signed [8:0] out_new_vel_row,
  output logic signed [8:0] out_new_vel_col,
  output logic             out_phase_done
);

  // config registers
  logic [10:0] grid_h_r, grid_w_r;
  logic [15:0] cog_w_r, soc_w_r, start_iner_r, iner_dec_r;
  logic [7:0]  speed_lim_r, phase_gens_r;
  logic [15:0] inertia_r;
  logic [7:0]  gen_r;

  state_t      state_r;
  logic [3:0]  cnt_r;
  logic        col_sel_r;

  logic [9:0]  pr_r, pc_r;
  logic signed [DIF_W-1:0] vr_r, vc_r, cr_r, cc_r, gr_r, gc_r;
  logic [15:0] r1_r, r2_r;
  logic        last_r;
  logic [31:0] p1_r, p2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [VEL_W-1:0] nr_r, nc_r;
  logic [33:0] sq_r;
  logic [10:0] mod_m_r;
  logic        mod_neg_r;
  logic [9:0]  row_res_r, col_res_r;

  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] prod_r;

  logic out_valid_r;
  logic [9:0] out_row_r, out_col_r;
  logic signed [8:0] out_vr_r, out_vc_r;
  logic out_done_r;

  logic [SIDE_W-1:0] side_h, side_w, side_cur;
  logic in_fire;
  logic signed [ACC_W-1:0] prod_s, sum_s;
  logic signed [VEL_W-1:0] trunc_v;
  logic [16:0] nr_mag, nc_mag;
  logic [20:0] mag9;
  logic [16:0] quot;
  logic [34:0] speed2;
  logic [15:0] lim2;
  logic signed [VEL_W:0] pos_sum;
  logic [VEL_W:0] pos_mag;
  logic [20:0] side_sh;
  logic [3:0]  mod_k;
  logic [10:0] mod_fix;
  logic [7:0]  gen_inc;
  logic        fin_go;

  assign side_h  = clamp_side(grid_h_r);
  assign side_w  = clamp_side(grid_w_r);
  assign side_cur = col_sel_r ? side_w : side_h;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign prod_s = prod_r[ACC_W-1:0];
  assign sum_s  = acc_r + prod_s;
  // truncate toward zero: floor, then bump negatives with a fraction
  assign trunc_v = VEL_W'(sum_s[ACC_W-1:FRAC_BITS+16])
                 + VEL_W'(sum_s[ACC_W-1] && (|sum_s[FRAC_BITS+15:0]));

  assign nr_mag = nr_r[VEL_W-1] ? 17'(-nr_r) : 17'(nr_r);
  assign nc_mag = nc_r[VEL_W-1] ? 17'(-nc_r) : 17'(nc_r);
  assign mag9   = ({4'b0, (cnt_r == 4'd0) ? nr_mag : nc_mag} << 3)
                + {4'b0, (cnt_r == 4'd0) ? nr_mag : nc_mag};
  assign quot   = prod_r[RECIP_SH+16:RECIP_SH];

  assign speed2 = {1'b0, sq_r} + {1'b0, prod_r[33:0]};
  assign lim2   = speed_lim_r * speed_lim_r;

  assign pos_sum = $signed({8'b0, col_sel_r ? pc_r : pr_r})
                 + (VEL_W+1)'(col_sel_r ? nc_r : nr_r);
  assign pos_mag = pos_sum[VEL_W] ? (VEL_W+1)'(-pos_sum) : (VEL_W+1)'(pos_sum);
  assign mod_k   = 4'd11 - cnt_r;
  assign side_sh = {10'b0, side_cur} << mod_k;
  assign mod_fix = (mod_neg_r && (mod_m_r != 11'd0)) ? side_cur - mod_m_r : mod_m_r;

  assign gen_inc = gen_r + 8'd1;
  assign fin_go  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL: begin
        unique case (cnt_r)
          4'd0: begin mul_a = $signed({17'b0, cog_w_r}); mul_b = $signed({5'b0, r1_r}); end
          4'd1: begin mul_a = $signed({17'b0, soc_w_r}); mul_b = $signed({5'b0, r2_r}); end
          4'd2: begin mul_a = $signed({17'b0, inertia_r}); mul_b = 21'(vr_r); end
          4'd3: begin mul_a = $signed({1'b0, p1_r}); mul_b = 21'(cr_r); end
          4'd4: begin mul_a = $signed({1'b0, p2_r}); mul_b = 21'(gr_r); end
          4'd5: begin mul_a = $signed({17'b0, inertia_r}); mul_b = 21'(vc_r); end
          4'd6: begin mul_a = $signed({1'b0, p1_r}); mul_b = 21'(cc_r); end
          4'd7: begin mul_a = $signed({1'b0, p2_r}); mul_b = 21'(gc_r); end
          default: ;
        endcase
      end
      ST_CHK: begin
        if (cnt_r == 4'd0) begin
          mul_a = 33'(nr_r); mul_b = 21'(nr_r);
        end else begin
          mul_a = 33'(nc_r); mul_b = 21'(nc_r);
        end
      end
      ST_DIV: begin
        mul_a = $signed({12'b0, mag9});
        mul_b = RECIP_10;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_h_r     <= 11'd256;
      grid_w_r     <= 11'd256;
      cog_w_r      <= 16'd4096;
      soc_w_r      <= 16'd8192;
      speed_lim_r  <= 8'd10;
      start_iner_r <= 16'd3686;
      iner_dec_r   <= 16'd573;
      phase_gens_r <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_HEIGHT: grid_h_r     <= cfg_data[10:0];
        REG_GRID_WIDTH:  grid_w_r     <= cfg_data[10:0];
        REG_COG_WEIGHT:  cog_w_r      <= cfg_data;
        REG_SOC_WEIGHT:  soc_w_r      <= cfg_data;
        REG_SPEED_LIMIT: speed_lim_r  <= cfg_data[7:0];
        REG_START_INER:  start_iner_r <= cfg_data;
        REG_INER_DEC:    iner_dec_r   <= cfg_data;
        REG_PHASE_GENS:  phase_gens_r <= cfg_data[7:0];
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      col_sel_r   <= 1'b0;
      inertia_r   <= 16'd3686;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_MUL;
            cnt_r   <= '0;
          end
        end
        ST_MUL: begin
          if (cnt_r == 4'd8) begin
            state_r <= ST_CHK;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_CHK: begin
          if (cnt_r == 4'd2) begin
            cnt_r     <= '0;
            col_sel_r <= 1'b0;
            state_r   <= (speed2 > {19'b0, lim2}) ? ST_DIV : ST_MOD;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_DIV: begin
          if (cnt_r == 4'd2) begin
            cnt_r   <= '0;
            state_r <= ST_CHK;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_MOD: begin
          if (cnt_r == 4'd12) begin
            cnt_r <= '0;
            if (col_sel_r) state_r <= ST_FIN;
            col_sel_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            state_r     <= ST_IDLE;
            if (last_r) begin
              if (gen_inc >= phase_gens_r) begin
                gen_r     <= '0;
                inertia_r <= start_iner_r;
              end else begin
                gen_r     <= gen_inc;
                inertia_r <= (inertia_r > iner_dec_r) ? inertia_r - iner_dec_r : 16'd0;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pr_r   <= in_pos_row;
      pc_r   <= in_pos_col;
      vr_r   <= shortest(DIF_W'(in_vel_row), side_h);
      vc_r   <= shortest(DIF_W'(in_vel_col), side_w);
      cr_r   <= shortest($signed({2'b0, in_own_best_row}) - $signed({2'b0, in_pos_row}), side_h);
      cc_r   <= shortest($signed({2'b0, in_own_best_col}) - $signed({2'b0, in_pos_col}), side_w);
      gr_r   <= shortest($signed({2'b0, in_swarm_best_row}) - $signed({2'b0, in_pos_row}),
                         side_h);
      gc_r   <= shortest($signed({2'b0, in_swarm_best_col}) - $signed({2'b0, in_pos_col}),
                         side_w);
      r1_r   <= in_rand_cognitive;
      r2_r   <= in_rand_social;
      last_r <= in_last_of_generation;
    end
    if (state_r == ST_MUL) begin
      unique case (cnt_r)
        4'd1: p1_r <= prod_r[31:0];
        4'd2: p2_r <= prod_r[31:0];
        4'd3, 4'd6: acc_r <= {prod_r[29:0], 16'b0};
        4'd4, 4'd7: acc_r <= sum_s;
        4'd5: nr_r <= trunc_v;
        4'd8: nc_r <= trunc_v;
        default: ;
      endcase
    end
    if (state_r == ST_CHK && cnt_r == 4'd1) sq_r <= prod_r[33:0];
    if (state_r == ST_DIV) begin
      if (cnt_r == 4'd1) nr_r <= nr_r[VEL_W-1] ? -$signed(quot) : $signed(quot);
      if (cnt_r == 4'd2) nc_r <= nc_r[VEL_W-1] ? -$signed(quot) : $signed(quot);
    end
    if (state_r == ST_MOD) begin
      if (cnt_r == 4'd0) begin
        mod_m_r   <= pos_mag[10:0];
        mod_neg_r <= pos_sum[VEL_W];
      end else if (cnt_r == 4'd12) begin
        if (col_sel_r) col_res_r <= mod_fix[9:0];
        else           row_res_r <= mod_fix[9:0];
      end else if ({10'b0, mod_m_r} >= side_sh) begin
        mod_m_r <= mod_m_r - side_sh[10:0];
      end
    end
    if (fin_go) begin
      out_row_r  <= row_res_r;
      out_col_r  <= col_res_r;
      out_vr_r   <= nr_r[8:0];
      out_vc_r   <= nc_r[8:0];
      out_done_r <= last_r && (gen_inc >= phase_gens_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_row     = out_row_r;
  assign out_new_col     = out_col_r;
  assign out_new_vel_row = out_vr_r;
  assign out_new_vel_col = out_vc_r;
  assign out_phase_done  = out_done_r;

`ifndef SYNTHESIS
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_MUL)
    else $error("accepted item did not start the product sequence");
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MOD |-> (nr_r <= 17'sd255 && nr_r >= -17'sd255 &&
                           nc_r <= 17'sd255 && nc_r >= -17'sd255))
    else $error("velocity outside speed clamp range at wrap");
  a_phase_reset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> gen_r == 8'd0)
    else $error("phase end reported without generation count cleared");
`endif

endmodule
`default_nettype wire
